[rtl/dra_pkg.sv]
`timescale 1ns / 1ps

package dra_pkg;

    // Reply framing
    localparam int MAX_BYTES  = 512;
    localparam int POS_W      = $clog2(MAX_BYTES + 1);
    localparam int HEADER_LEN = 12;

    // Header byte positions that carry a field
    localparam logic [POS_W-1:0] HDR_ID_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] HDR_FLAGS  = POS_W'(2);
    localparam logic [POS_W-1:0] HDR_RCODE  = POS_W'(3);
    localparam logic [POS_W-1:0] HDR_QD_LO  = POS_W'(5);
    localparam logic [POS_W-1:0] HDR_AN_LO  = POS_W'(7);
    localparam logic [POS_W-1:0] HDR_LAST   = POS_W'(HEADER_LEN - 1);

    // Fixed part of a question and of an answer record, in field bytes
    localparam logic [3:0] QFIX_LAST   = 4'd4;
    localparam logic [3:0] AFIX_LAST   = 4'd10;
    localparam logic [3:0] AFIX_TYPE_H = 4'd0;
    localparam logic [3:0] AFIX_TYPE_L = 4'd1;
    localparam logic [3:0] AFIX_LEN_H  = 4'd8;
    localparam logic [3:0] AFIX_LEN_L  = 4'd9;

    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] A_DATALEN = 16'd4;
    localparam logic [1:0]  PTR_MARK  = 2'b11;

    // Result kinds
    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes; the header error register uses the same codes
    localparam logic [2:0] ST_FOUND        = 3'd0;
    localparam logic [2:0] ST_SHORT        = 3'd1;
    localparam logic [2:0] ST_ID_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd3;
    localparam logic [2:0] ST_SERVER_ERROR = 3'd4;
    localparam logic [2:0] ST_NONE         = 3'd5;
    localparam logic [2:0] HERR_CLEAR      = 3'd0;

    // Register map
    localparam int          PADDR_W         = 3;
    localparam logic        REG_EXPECTED_ID = 1'b0;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_QFIXED = 3'd4,
        PH_AFIXED = 3'd5,
        PH_ADATA  = 3'd6,
        PH_IDLE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [2:0]  status;
        logic [3:0]  server_code;
        logic        final_res;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[rtl/dra_cfg_regs.sv]
`timescale 1ns / 1ps

module dra_cfg_regs
    import dra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [15:0]        expected_id
);

    logic [15:0] expected_id_reg;
    logic [15:0] expected_id_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_EXPECTED_ID);

    always_comb
    begin
        expected_id_next = expected_id_reg;
        if (wr_en)
        begin
            expected_id_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
        end
        else
        begin
            expected_id_reg <= expected_id_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EXPECTED_ID: prdata = {16'd0, expected_id_reg};
            default:         prdata = '0;
        endcase
    end

    assign expected_id = expected_id_reg;

endmodule

[rtl/dra_parser.sv]
`timescale 1ns / 1ps

module dra_parser
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic [15:0] expected_id,
    output push_t       push
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       qleft_reg, qleft_next;
    logic [15:0]       aleft_reg, aleft_next;
    logic [7:0]        skip_reg, skip_next;
    logic [3:0]        fidx_reg, fidx_next;
    logic [15:0]       rtype_reg, rtype_next;
    logic [15:0]       dlen_reg, dlen_next;
    logic [31:0]       accum_reg, accum_next;
    logic              found_reg, found_next;
    logic [2:0]        herr_reg, herr_next;
    logic [7:0]        held_reg, held_next;
    logic [3:0]        rcode_reg, rcode_next;

    logic [3:0]        fidx_inc;
    logic [15:0]       qleft_dec;
    logic [15:0]       aleft_dec;
    logic [7:0]        skip_dec;
    logic [15:0]       dlen_dec;
    logic [15:0]       word_in;
    logic              addr_hit;
    logic              status_hit;
    logic [2:0]        status_code;
    logic [3:0]        status_rcode;

    assign fidx_inc  = fidx_reg + 4'd1;
    assign qleft_dec = qleft_reg - 16'd1;
    assign aleft_dec = aleft_reg - 16'd1;
    assign skip_dec  = skip_reg - 8'd1;
    assign dlen_dec  = dlen_reg - 16'd1;
    assign word_in   = {held_reg, byte_value};

    // Next state of the parse for the beat at the input
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        skip_next    = skip_reg;
        fidx_next    = fidx_reg;
        rtype_next   = rtype_reg;
        dlen_next    = dlen_reg;
        accum_next   = accum_reg;
        found_next   = found_reg;
        herr_next    = herr_reg;
        held_next    = held_reg;
        rcode_next   = rcode_reg;
        addr_hit     = 1'b0;
        status_hit   = 1'b0;
        status_code  = ST_FOUND;
        status_rcode = 4'd0;

        if (accept)
        begin
            if (pos_reg < POS_W'(MAX_BYTES))
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        case (pos_reg)
                            HDR_ID_LO:
                            begin
                                if (herr_reg == HERR_CLEAR && word_in != expected_id)
                                begin
                                    herr_next = ST_ID_MISMATCH;
                                end
                            end
                            HDR_FLAGS:
                            begin
                                if (herr_reg == HERR_CLEAR && !byte_value[7])
                                begin
                                    herr_next = ST_NOT_RESPONSE;
                                end
                            end
                            HDR_RCODE:
                            begin
                                rcode_next = byte_value[3:0];
                                if (herr_reg == HERR_CLEAR && byte_value[3:0] != 4'd0)
                                begin
                                    herr_next = ST_SERVER_ERROR;
                                end
                            end
                            HDR_QD_LO: qleft_next = word_in;
                            HDR_AN_LO: aleft_next = word_in;
                            HDR_LAST:
                            begin
                                if (herr_reg != HERR_CLEAR)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else if (qleft_reg != 16'd0 || aleft_reg != 16'd0)
                                begin
                                    phase_next = PH_NAME;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                        held_next = byte_value;
                    end
                    PH_NAME:
                    begin
                        if (byte_value == 8'd0)
                        begin
                            fidx_next  = 4'd0;
                            phase_next = (qleft_reg != 16'd0) ? PH_QFIXED : PH_AFIXED;
                        end
                        else if (byte_value[7:6] == PTR_MARK)
                        begin
                            phase_next = PH_PTR;
                        end
                        else
                        begin
                            skip_next  = byte_value;
                            phase_next = PH_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                    PH_PTR:
                    begin
                        fidx_next  = 4'd0;
                        phase_next = (qleft_reg != 16'd0) ? PH_QFIXED : PH_AFIXED;
                    end
                    PH_QFIXED:
                    begin
                        fidx_next = fidx_inc;
                        if (fidx_inc >= QFIX_LAST)
                        begin
                            qleft_next = qleft_dec;
                            phase_next = (qleft_dec != 16'd0 || aleft_reg != 16'd0) ?
                                         PH_NAME : PH_IDLE;
                        end
                    end
                    PH_AFIXED:
                    begin
                        case (fidx_reg)
                            AFIX_TYPE_H: rtype_next = {byte_value, 8'd0};
                            AFIX_TYPE_L: rtype_next = rtype_reg | {8'd0, byte_value};
                            AFIX_LEN_H:  dlen_next  = {byte_value, 8'd0};
                            AFIX_LEN_L:  dlen_next  = dlen_reg | {8'd0, byte_value};
                            default: ;
                        endcase
                        fidx_next = fidx_inc;
                        if (fidx_inc >= AFIX_LAST)
                        begin
                            if (!(rtype_next == TYPE_A && dlen_next == A_DATALEN))
                            begin
                                rtype_next = 16'd0;
                            end
                            accum_next = 32'd0;
                            if (dlen_next == 16'd0)
                            begin
                                aleft_next = aleft_dec;
                                phase_next = (qleft_reg != 16'd0 || aleft_dec != 16'd0) ?
                                             PH_NAME : PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_ADATA;
                            end
                        end
                    end
                    PH_ADATA:
                    begin
                        accum_next = {accum_reg[23:0], byte_value};
                        dlen_next  = dlen_dec;
                        if (dlen_dec == 16'd0)
                        begin
                            if (rtype_reg == TYPE_A)
                            begin
                                found_next = 1'b1;
                                addr_hit   = 1'b1;
                            end
                            aleft_next = aleft_dec;
                            phase_next = (qleft_reg != 16'd0 || aleft_dec != 16'd0) ?
                                         PH_NAME : PH_IDLE;
                        end
                    end
                    PH_IDLE: ;
                    default: ;
                endcase
                pos_next = pos_reg + POS_W'(1);
            end

            if (last_byte)
            begin
                status_hit = 1'b1;
                if (pos_next < POS_W'(HEADER_LEN))
                begin
                    status_code = ST_SHORT;
                end
                else if (herr_next != HERR_CLEAR)
                begin
                    status_code = herr_next;
                end
                else
                begin
                    status_code = found_next ? ST_FOUND : ST_NONE;
                end
                status_rcode = (status_code == ST_SERVER_ERROR) ? rcode_next : 4'd0;

                // Return to the reset state for the next reply
                phase_next = PH_HEADER;
                pos_next   = '0;
                qleft_next = '0;
                aleft_next = '0;
                skip_next  = '0;
                fidx_next  = '0;
                rtype_next = '0;
                dlen_next  = '0;
                accum_next = '0;
                found_next = 1'b0;
                herr_next  = HERR_CLEAR;
                held_next  = '0;
                rcode_next = '0;
            end
        end
    end

    // Results of the beat: address first, then the status
    always_comb
    begin
        result_t addr_res;
        result_t stat_res;
        addr_res             = '0;
        addr_res.kind        = KIND_ADDR;
        addr_res.address     = {accum_reg[23:0], byte_value};
        stat_res             = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.status      = status_code;
        stat_res.server_code = status_rcode;
        stat_res.final_res   = 1'b1;

        push.count  = {1'b0, addr_hit} + {1'b0, status_hit};
        push.first  = addr_hit ? addr_res : stat_res;
        push.second = stat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            qleft_reg <= '0;
            aleft_reg <= '0;
            skip_reg  <= '0;
            fidx_reg  <= '0;
            rtype_reg <= '0;
            dlen_reg  <= '0;
            accum_reg <= '0;
            found_reg <= 1'b0;
            herr_reg  <= HERR_CLEAR;
            held_reg  <= '0;
            rcode_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            qleft_reg <= qleft_next;
            aleft_reg <= aleft_next;
            skip_reg  <= skip_next;
            fidx_reg  <= fidx_next;
            rtype_reg <= rtype_next;
            dlen_reg  <= dlen_next;
            accum_reg <= accum_next;
            found_reg <= found_next;
            herr_reg  <= herr_next;
            held_reg  <= held_next;
            rcode_reg <= rcode_next;
        end
    end

endmodule

[rtl/dra_result_fifo.sv]
`timescale 1ns / 1ps

module dra_result_fifo
    import dra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    no_room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_2nd;
    logic                  pop;

    // Hold off the input unless a two-result beat still fits
    assign no_room    = cnt_reg > FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid  = cnt_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign head       = slot_reg[rd_ptr_reg];
    assign wr_ptr_2nd = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_2nd] <= push.second;
        end
    end

endmodule

[rtl/dns_reply_address_extractor_top.sv]
`timescale 1ns / 1ps

// DNS reply address extractor.
// Input channel: one reply byte per beat (byte_value, last_byte) under
// in_valid / in_stall. last_byte closes the reply; the parser then starts
// over on the next byte.
// Output channel: one result per beat (kind, address, status, server_code,
// final_res) under out_valid / out_stall. Each A record with four data bytes
// gives an address beat; the closing byte gives a status beat with final_res.
// Results are registered in the result queue and presented from its head.
// Throughput: one byte per cycle while in_stall is low; the parse state
// advances in the same cycle the byte is taken. A closing byte that also
// completes an address puts two results in the four-entry result queue.
// in_stall rises while the queue has fewer than two free entries, so a
// stalled receiver backs up into the input after three or four results.
// expected_id is written through the APB port at byte address 0; the user
// must write it only while the block is idle, which the block itself does
// not enforce.
// Reset: clears the parse state, empties the result queue and sets
// expected_id to zero.
module dns_reply_address_extractor_top
    import dra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [31:0]        address,
    output logic [2:0]         status,
    output logic [3:0]         server_code,
    output logic               final_res
);

    logic [15:0] expected_id;
    logic        accept;
    push_t       push;
    result_t     head;

    assign accept = in_valid && !in_stall;

    dra_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .expected_id (expected_id)
    );

    // Advance the parse on every accepted beat
    dra_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .expected_id (expected_id),
        .push        (push)
    );

    // Queue results so the input keeps moving while the output waits
    dra_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .no_room   (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind        = head.kind;
    assign address     = head.address;
    assign status      = head.status;
    assign server_code = head.server_code;
    assign final_res   = head.final_res;

`ifndef SYNTHESIS
    a_last_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |-> push.count != 2'd0)
        else $error("closing byte produced no status result");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.second.final_res && !push.first.final_res)
        else $error("two-result beat out of order");

    a_final_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_res |-> kind == KIND_STATUS)
        else $error("final result is not a status");

    a_addr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ADDR |-> status == ST_FOUND && server_code == 4'd0)
        else $error("address result carries status bits");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dra_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam int HOLDOFF_BEATS = 300;
    // First register index past the map; writes there must be ignored
    localparam int REG_UNMAPPED  = 1;

    localparam logic [7:0]  FLAG_QR   = 8'h80;
    localparam logic [7:0]  PTR_BYTE  = 8'hC0;
    localparam logic [15:0] RR_CNAME  = 16'd5;
    localparam logic [15:0] RR_AAAA   = 16'd28;
    localparam logic [15:0] RR_A_HIGH = 16'h0101;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         byte_value;
    logic               last_byte;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic [31:0]        address;
    logic [2:0]         status;
    logic [3:0]         server_code;
    logic               final_res;

    dns_reply_address_extractor_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .address     (address),
        .status      (status),
        .server_code (server_code),
        .final_res   (final_res)
    );

    // Parser mirror: one copy of the walk state plus the id register
    phase_t           parse_phase;
    logic [POS_W-1:0] parse_pos;
    logic [15:0]      questions_left;
    logic [15:0]      answers_left;
    logic [7:0]       label_left;
    logic [3:0]       fixed_index;
    logic [15:0]      record_type;
    logic [15:0]      data_left;
    logic [31:0]      address_accum;
    logic             address_found;
    logic [2:0]       header_fault;
    logic [7:0]       held_byte;
    logic [3:0]       held_rcode;
    logic [15:0]      cfg_expected_id;

    // Results still owed by the block, oldest first
    result_t    owed_results[$];
    // Reply under construction
    logic [7:0] reply_buf[$];

    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  results_seen   = 0;
    int  receiver_hold  = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;

    // Free-running clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Parser mirror
    // ---------------------------------------------------------------
    function automatic void clear_parse_state();
        parse_phase    = PH_HEADER;
        parse_pos      = '0;
        questions_left = '0;
        answers_left   = '0;
        label_left     = '0;
        fixed_index    = '0;
        record_type    = '0;
        data_left      = '0;
        address_accum  = '0;
        address_found  = 1'b0;
        header_fault   = HERR_CLEAR;
        held_byte      = '0;
        held_rcode     = '0;
    endfunction

    function automatic void owe_result(input logic k, input logic [31:0] a,
                                       input logic [2:0] s, input logic [3:0] c,
                                       input logic f);
        result_t r;
        r.kind        = k;
        r.address     = a;
        r.status      = s;
        r.server_code = c;
        r.final_res   = f;
        owed_results.push_back(r);
    endfunction

    // Go to the next name, or stop once both sections are used up
    function automatic void advance_entry();
        if (questions_left != 0 || answers_left != 0)
            parse_phase = PH_NAME;
        else
            parse_phase = PH_IDLE;
    endfunction

    function automatic void close_record();
        answers_left = answers_left - 16'd1;
        advance_entry();
    endfunction

    function automatic void close_name();
        fixed_index = '0;
        parse_phase = (questions_left != 0) ? PH_QFIXED : PH_AFIXED;
    endfunction

    // Advance the mirror by one accepted beat and queue what it owes
    function automatic void track_reply_byte(input logic [7:0] b, input logic closing);
        logic [2:0] st;
        logic [3:0] code;
        if (parse_pos < MAX_BYTES)
        begin
            case (parse_phase)
                PH_HEADER:
                begin
                    if (parse_pos == HDR_ID_LO)
                    begin
                        if (header_fault == HERR_CLEAR && {held_byte, b} != cfg_expected_id)
                            header_fault = ST_ID_MISMATCH;
                    end
                    else if (parse_pos == HDR_FLAGS)
                    begin
                        if (header_fault == HERR_CLEAR && (b & FLAG_QR) == 8'h00)
                            header_fault = ST_NOT_RESPONSE;
                    end
                    else if (parse_pos == HDR_RCODE)
                    begin
                        held_rcode = b[3:0];
                        if (header_fault == HERR_CLEAR && held_rcode != 4'd0)
                            header_fault = ST_SERVER_ERROR;
                    end
                    else if (parse_pos == HDR_QD_LO)
                        questions_left = {held_byte, b};
                    else if (parse_pos == HDR_AN_LO)
                        answers_left = {held_byte, b};
                    else if (parse_pos == HDR_LAST)
                    begin
                        if (header_fault != HERR_CLEAR)
                            parse_phase = PH_IDLE;
                        else
                            advance_entry();
                    end
                    held_byte = b;
                end
                PH_NAME:
                begin
                    if (b == 8'h00)
                        close_name();
                    else if (b[7:6] == PTR_MARK)
                        parse_phase = PH_PTR;
                    else
                    begin
                        // 0x40..0xBF counts as a plain label length too
                        label_left  = b;
                        parse_phase = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    label_left = label_left - 8'd1;
                    if (label_left == 8'd0)
                        parse_phase = PH_NAME;
                end
                PH_PTR:
                    close_name();
                PH_QFIXED:
                begin
                    fixed_index = fixed_index + 4'd1;
                    if (fixed_index >= QFIX_LAST)
                    begin
                        questions_left = questions_left - 16'd1;
                        advance_entry();
                    end
                end
                PH_AFIXED:
                begin
                    if (fixed_index == AFIX_TYPE_H)
                        record_type = {b, 8'h00};
                    else if (fixed_index == AFIX_TYPE_L)
                        record_type = record_type | {8'h00, b};
                    else if (fixed_index == AFIX_LEN_H)
                        data_left = {b, 8'h00};
                    else if (fixed_index == AFIX_LEN_L)
                        data_left = data_left | {8'h00, b};
                    fixed_index = fixed_index + 4'd1;
                    if (fixed_index >= AFIX_LAST)
                    begin
                        // Only a four-byte A record keeps its type
                        if (!(record_type == TYPE_A && data_left == A_DATALEN))
                            record_type = '0;
                        address_accum = '0;
                        if (data_left == 16'd0)
                            close_record();
                        else
                            parse_phase = PH_ADATA;
                    end
                end
                PH_ADATA:
                begin
                    address_accum = {address_accum[23:0], b};
                    data_left     = data_left - 16'd1;
                    if (data_left == 16'd0)
                    begin
                        if (record_type == TYPE_A)
                        begin
                            address_found = 1'b1;
                            owe_result(KIND_ADDR, address_accum, ST_FOUND, 4'd0, 1'b0);
                        end
                        close_record();
                    end
                end
                default: ;
            endcase
            parse_pos = parse_pos + 1'b1;
        end

        if (closing)
        begin
            code = 4'd0;
            if (parse_pos < HEADER_LEN)
                st = ST_SHORT;
            else if (header_fault != HERR_CLEAR)
                st = header_fault;
            else
                st = address_found ? ST_FOUND : ST_NONE;
            if (st == ST_SERVER_ERROR)
                code = held_rcode;
            owe_result(KIND_STATUS, 32'd0, st, code, 1'b1);
            clear_parse_state();
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Mostly back-to-back, a few short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        if (!sender_idles)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int receiver_stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one beat, hold it until the block takes it, then update the mirror
    task automatic send_byte(input logic [7:0] value, input logic closing);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_value = value;
        last_byte  = closing;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_reply_byte(value, closing);
        bytes_sent++;
    endtask

    // Send reply_buf[first..stop-1]; the final byte of the buffer closes the reply
    task automatic send_span(input int first, input int stop);
        for (int i = first; i < stop; i++)
            send_byte(reply_buf[i], i == reply_buf.size() - 1);
    endtask

    task automatic send_reply();
        send_span(0, reply_buf.size());
    endtask

    // Drop valid and hold off until every owed result has been taken
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup beat, then access beat; settle first so the block is idle
    task automatic apb_write(input int index, input logic [31:0] data);
        wait_for_drain();
        repeat (3) @(negedge clk);
        paddr   = PADDR_W'(index * 4);
        pwdata  = data;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (index == int'(REG_EXPECTED_ID))
            cfg_expected_id = data[15:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Upper data bits are noise; only the low half belongs to the register
    task automatic set_expected_id(input logic [15:0] id);
        apb_write(int'(REG_EXPECTED_ID), {16'($urandom), id});
    endtask

    // ---------------------------------------------------------------
    // Reply construction
    // ---------------------------------------------------------------
    task automatic put_header(input logic [15:0] id, input logic [7:0] flags_hi,
                              input logic [7:0] flags_lo, input logic [15:0] qd,
                              input logic [15:0] an);
        reply_buf.push_back(id[15:8]);
        reply_buf.push_back(id[7:0]);
        reply_buf.push_back(flags_hi);
        reply_buf.push_back(flags_lo);
        reply_buf.push_back(qd[15:8]);
        reply_buf.push_back(qd[7:0]);
        reply_buf.push_back(an[15:8]);
        reply_buf.push_back(an[7:0]);
        repeat (4) reply_buf.push_back(8'($urandom));
    endtask

    task automatic put_label(input int len);
        reply_buf.push_back(8'(len));
        repeat (len) reply_buf.push_back(8'($urandom));
    endtask

    task automatic put_pointer();
        reply_buf.push_back(PTR_BYTE | 8'($urandom_range(0, 63)));
        reply_buf.push_back(8'($urandom));
    endtask

    // Random owner name: root, pointer, labels ending in root or pointer,
    // and rarely a label whose length byte sits in 0x40..0xBF
    task automatic put_name();
        int style;
        style = $urandom_range(0, 19);
        if (style == 0)
            reply_buf.push_back(8'h00);
        else if (style <= 5)
            put_pointer();
        else
        begin
            if (style == 6)
                put_label($urandom_range(64, 191));
            repeat ($urandom_range(1, 3)) put_label($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
                put_pointer();
            else
                reply_buf.push_back(8'h00);
        end
    endtask

    task automatic put_question();
        put_name();
        repeat (4) reply_buf.push_back(8'($urandom));
    endtask

    // Answer record; fill < 0 gives random data bytes
    task automatic put_record(input logic [15:0] rtype, input logic [15:0] rlen,
                              input int fill);
        put_name();
        reply_buf.push_back(rtype[15:8]);
        reply_buf.push_back(rtype[7:0]);
        repeat (6) reply_buf.push_back(8'($urandom));
        reply_buf.push_back(rlen[15:8]);
        reply_buf.push_back(rlen[7:0]);
        repeat (rlen)
            reply_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    task automatic put_random_record();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            put_record(TYPE_A, A_DATALEN, -1);
        else if (r < 14)
            put_record(TYPE_A, 16'($urandom_range(0, 6)), -1);
        else if (r < 17)
            put_record({7'd0, 1'($urandom), 8'($urandom)}, 16'($urandom_range(0, 8)), -1);
        else if (r < 18)
            put_record(RR_AAAA, 16'd16, -1);
        else
            put_record(RR_A_HIGH, A_DATALEN, -1);
    endtask

    // Mostly well-formed replies with random content; the rest carry a
    // header fault, are cut short, or are plain noise
    task automatic build_random_reply();
        int          pick;
        int          cut;
        int          n_q;
        int          n_a;
        logic [15:0] id;
        logic [7:0]  flags_hi;
        logic [7:0]  flags_lo;
        reply_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 24)) reply_buf.push_back(8'($urandom));
            return;
        end
        id       = cfg_expected_id;
        flags_hi = 8'($urandom) | FLAG_QR;
        flags_lo = 8'($urandom) & 8'hF0;
        if (pick < 22)
        begin
            case ($urandom_range(0, 3))
                0: id = id ^ 16'(1 << $urandom_range(0, 15));
                1: flags_hi = flags_hi & ~FLAG_QR;
                2: flags_lo = flags_lo | 8'($urandom_range(1, 15));
                default:
                begin
                    id       = 16'($urandom);
                    flags_hi = 8'($urandom);
                    flags_lo = 8'($urandom);
                end
            endcase
        end
        n_q = $urandom_range(0, 2);
        n_a = $urandom_range(0, 4);
        put_header(id, flags_hi, flags_lo, 16'(n_q), 16'(n_a));
        repeat (n_q) put_question();
        repeat (n_a) put_random_record();
        repeat ($urandom_range(0, 2)) reply_buf.push_back(8'($urandom));
        if (pick >= 22 && pick < 34)
        begin
            cut = $urandom_range(1, reply_buf.size());
            while (reply_buf.size() > cut)
                void'(reply_buf.pop_back());
        end
    endtask

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------
    // Receiver: a commanded hold-off first, otherwise random stall runs
    initial
    begin : receiver
        int run_left;
        run_left  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                out_stall = 1'b1;
                receiver_hold--;
            end
            else if (run_left > 0)
                run_left--;
            else if (out_stall || !receiver_idles)
            begin
                out_stall = 1'b0;
                run_left  = receiver_idles ? $urandom_range(0, 6) : 0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall = 1'b1;
                run_left  = receiver_stall_length() - 1;
            end
        end
    end

    // Compare every taken result beat with the oldest owed one
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (owed_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0d status=%0d",
                                          kind, status));
            else
            begin
                want = owed_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (address !== want.address)
                    report_mismatch($sformatf("address %h, want %h", address, want.address));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (server_code !== want.server_code)
                    report_mismatch($sformatf("server_code %0d, want %0d",
                                              server_code, want.server_code));
                if (final_res !== want.final_res)
                    report_mismatch($sformatf("final_res %0d, want %0d",
                                              final_res, want.final_res));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Id register comes out of reset as zero; all-ones, all-zeros and random
    // addresses, the last one closing the reply so two results land together
    task automatic test_reset_id_and_addresses();
        reply_buf.delete();
        put_header(16'h0000, FLAG_QR, 8'h00, 16'd0, 16'd3);
        put_record(TYPE_A, A_DATALEN, 8'hFF);
        put_record(TYPE_A, A_DATALEN, 8'h00);
        put_record(TYPE_A, A_DATALEN, -1);
        send_reply();
        wait_for_drain();
    endtask

    // Header faults in priority order, plus an unmapped register write
    task automatic test_header_checks();
        set_expected_id(16'hA5C3);
        // one-byte reply
        reply_buf.delete();
        reply_buf.push_back(8'hA5);
        send_reply();
        // eleven bytes of a good header
        reply_buf.delete();
        put_header(16'hA5C3, FLAG_QR, 8'h00, 16'd0, 16'd0);
        void'(reply_buf.pop_back());
        send_reply();
        // short beats a bad id
        reply_buf.delete();
        put_header(16'h1234, 8'h00, 8'h0F, 16'd0, 16'd0);
        while (reply_buf.size() > 6)
            void'(reply_buf.pop_back());
        send_reply();
        // bad id beats the other faults; trailing record ignored
        reply_buf.delete();
        put_header(16'hA5C2, 8'h00, 8'h05, 16'd0, 16'd1);
        put_record(TYPE_A, A_DATALEN, -1);
        send_reply();
        // response bit clear beats rcode
        reply_buf.delete();
        put_header(16'hA5C3, 8'h7F, 8'h03, 16'd0, 16'd0);
        send_reply();
        // server error with the widest rcode
        reply_buf.delete();
        put_header(16'hA5C3, 8'hFF, 8'hFF, 16'd1, 16'd1);
        put_question();
        send_reply();
        // clean header, no entries
        reply_buf.delete();
        put_header(16'hA5C3, FLAG_QR, 8'h00, 16'd0, 16'd0);
        send_reply();
        // write past the map must leave the id alone
        apb_write(REG_UNMAPPED, 32'h0000_1234);
        reply_buf.delete();
        put_header(16'hA5C3, FLAG_QR, 8'h00, 16'd0, 16'd1);
        put_record(TYPE_A, A_DATALEN, -1);
        send_reply();
        wait_for_drain();
    endtask

    // Labels, pointers, odd label lengths, and records that must be skipped
    task automatic test_names_and_records();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd3, 16'd6);
        put_label(3);
        put_label(2);
        reply_buf.push_back(8'h00);
        repeat (4) reply_buf.push_back(8'($urandom));
        put_pointer();
        repeat (4) reply_buf.push_back(8'($urandom));
        put_label(8'h40);
        put_label(8'hBF);
        reply_buf.push_back(8'h00);
        repeat (4) reply_buf.push_back(8'($urandom));
        put_record(TYPE_A, 16'd5, -1);
        put_record(RR_AAAA, A_DATALEN, -1);
        put_record(TYPE_A, 16'd0, -1);
        put_record(RR_A_HIGH, A_DATALEN, -1);
        put_record(RR_CNAME, 16'd7, -1);
        put_record(TYPE_A, A_DATALEN, -1);
        // bytes past the last answer are ignored
        reply_buf.push_back(8'($urandom));
        reply_buf.push_back(8'($urandom));
        send_reply();
        wait_for_drain();
    endtask

    // Replies that stop mid-record, mid-name and on a pointer byte
    task automatic test_early_end();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd0, 16'd1);
        put_record(TYPE_A, A_DATALEN, -1);
        void'(reply_buf.pop_back());
        void'(reply_buf.pop_back());
        send_reply();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd1, 16'd1);
        put_label(5);
        void'(reply_buf.pop_back());
        send_reply();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd0, 16'd1);
        reply_buf.push_back(PTR_BYTE);
        send_reply();
        wait_for_drain();
    endtask

    // Reply longer than the parse window; the next reply must start clean
    task automatic test_long_reply();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd0, 16'd2);
        put_record(RR_CNAME, 16'd490, -1);
        put_record(TYPE_A, A_DATALEN, -1);
        while (reply_buf.size() < MAX_BYTES + 30)
            reply_buf.push_back(8'($urandom));
        send_reply();
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd0, 16'd1);
        put_record(TYPE_A, A_DATALEN, -1);
        send_reply();
        wait_for_drain();
    endtask

    // Hold the receiver off while beats keep coming, so the result queue
    // fills and the input stalls
    task automatic test_receiver_holdoff();
        sender_idles = 1'b0;
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd0, 16'd8);
        repeat (8) put_record(TYPE_A, A_DATALEN, -1);
        @(negedge clk);
        receiver_hold = HOLDOFF_BEATS;
        send_reply();
        wait_for_drain();
        sender_idles = 1'b1;
    endtask

    // Pause the sender mid-reply until every owed result has come
    task automatic test_sender_pause();
        int half;
        reply_buf.delete();
        put_header(cfg_expected_id, FLAG_QR, 8'h00, 16'd1, 16'd4);
        put_question();
        repeat (4) put_record(TYPE_A, A_DATALEN, -1);
        half = reply_buf.size() / 2;
        send_span(0, half);
        wait_for_drain();
        send_span(half, reply_buf.size());
        wait_for_drain();
    endtask

    // Random replies over several id settings, extremes included;
    // the second setting runs with no idling on either side
    task automatic test_random_replies();
        logic [15:0] ids[4];
        int          start_bytes;
        int          start_results;
        ids = '{16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom)};
        for (int p = 0; p < 4; p++)
        begin
            set_expected_id(ids[p]);
            sender_idles   = (p != 1);
            receiver_idles = (p != 1);
            start_bytes    = bytes_sent;
            start_results  = results_seen;
            while (bytes_sent - start_bytes < 115 || results_seen - start_results < 18)
            begin
                build_random_reply();
                send_reply();
            end
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        // Drive every input known before the first edge
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        byte_value = '0;
        last_byte  = 1'b0;
        cfg_expected_id = '0;
        clear_parse_state();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_id_and_addresses();
        test_header_checks();
        test_names_and_records();
        test_early_end();
        test_long_reply();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_replies();

        // Drain, then give the block time to show any stray beat
        wait_for_drain();
        repeat (10) @(negedge clk);
        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #RUN_LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/dra_pkg.sv
rtl/dra_cfg_regs.sv
rtl/dra_parser.sv
rtl/dra_result_fifo.sv
rtl/dns_reply_address_extractor_top.sv
tb/sv/testbench.sv
